// ===== rtl/core/fatcc_pkg.sv =====
// Shared types, codes and constants for the FAT16 cluster chain engine.
package fatcc_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam int CNT_W = 13;
	localparam int SKIP_W = 23;
	localparam int OFFS_W = 19;
	localparam int CFG_IDX_W = 2;

	// opcodes
	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_READ = 3'd1;
	localparam logic [2:0] OP_ALLOC = 3'd2;
	localparam logic [2:0] OP_FREE = 3'd3;
	localparam logic [2:0] OP_SEEK = 3'd4;

	// result status codes
	localparam logic [2:0] ST_LINK = 3'd0;
	localparam logic [2:0] ST_EOC = 3'd1;
	localparam logic [2:0] ST_FREE = 3'd2;
	localparam logic [2:0] ST_BAD = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPC_LOG2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BPS_LOG2 = 2'd3;

	// link values
	localparam logic [15:0] LINK_EOC_MIN = 16'hFFF8;
	localparam logic [15:0] LINK_BAD = 16'hFFF7;
	localparam logic [15:0] LINK_EOC = 16'hFFFF;
	localparam logic [15:0] LINK_FREE = 16'h0000;
	localparam logic [15:0] CL_FIRST = 16'd2;

	localparam logic [CNT_W-1:0] FREED_MAX = 13'h1FFF;
	localparam logic [CNT_W-1:0] CLUSTER_COUNT_RST = 13'd4096;
	localparam logic [3:0] BPS_MIN = 4'd9;
	localparam logic [3:0] BPS_MAX = 4'd12;

	typedef struct packed {
		logic [2:0] opcode;
		logic [15:0] cluster;
		logic [15:0] entry_data;
		logic [31:0] byte_position;
		logic [31:0] file_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] cluster_out;
		logic [15:0] link_value;
		logic [31:0] sector_address;
		logic [CNT_W-1:0] freed_count;
		logic [31:0] position_out;
		logic [OFFS_W-1:0] offset_in_cluster;
	} out_item_t;

	// table write request
	typedef struct packed {
		logic en;
		logic [15:0] addr;
		logic [15:0] data;
	} tab_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_READ,
		S_ALLOC_SCAN,
		S_ALLOC_LINK,
		S_FREE,
		S_WALK,
		S_DONE
	} state_t;

	function automatic logic [2:0] link_class(input logic [15:0] v);
		logic [2:0] c;
		if (v >= LINK_EOC_MIN)
			c = ST_EOC;
		else if (v == LINK_BAD)
			c = ST_BAD;
		else if (v < CL_FIRST)
			c = ST_FREE;
		else
			c = ST_LINK;
		return c;
	endfunction

endpackage

// ===== rtl/core/fat16_cluster_chain_engine.sv =====
// Top level of the FAT16 cluster chain engine: command sequencer around the cluster table.
//
//  channel | handshake           | payload                     | moves
//  --------+---------------------+-----------------------------+-------------------------
//  in      | in_valid / in_ready | in_item  (in_item_t)        | one command item
//  out     | out_valid/out_ready | out_item (out_item_t)       | one result item per command
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data         | one register write
//
// One item at a time: load writes one entry, read link reads one, allocate scans up from
// index 2 to the limit plus a link write when linking, free chain clears each chain entry,
// seek walks links, ending early at a non-link entry. Walks read one entry per cycle.
// Reset clears control and configuration only; table contents are undefined until loaded.
// A result waits in the output register; the next item is taken meanwhile and stalls only
// at its own result stage while out_ready is low. cfg_ready is always high.
module fat16_cluster_chain_engine (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  fatcc_pkg::in_item_t                    in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output fatcc_pkg::out_item_t                   out_item,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [fatcc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                            cfg_data
);

	fatcc_pkg::state_t state_q, state_d;

	// configuration
	logic [fatcc_pkg::CNT_W-1:0] cluster_count_q;
	logic [31:0]                 data_start_q;
	logic [2:0]                  spc_log2_q;
	logic [3:0]                  bps_log2_q;

	// captured command
	logic [2:0]  op_q, op_d;
	logic [15:0] cl_q, cl_d;
	logic [15:0] edata_q, edata_d;
	logic [31:0] pos_q, pos_d;    // already clamped to file length

	// walk / scan state
	logic [15:0]                  cur_q, cur_d;
	logic [fatcc_pkg::SKIP_W-1:0] skip_q, skip_d;
	logic [fatcc_pkg::CNT_W-1:0]  scan_q, scan_d;
	logic [fatcc_pkg::CNT_W-1:0]  lim_q, lim_d;
	logic                         rd_pend_s1, rd_pend_d;
	logic [15:0]                  rd_idx_s1, rd_idx_d;

	// result under construction
	logic [2:0]                   status_q, status_d;
	logic [15:0]                  cout_q, cout_d;
	logic [15:0]                  link_q, link_d;
	logic [fatcc_pkg::CNT_W-1:0]  freed_q, freed_d;
	logic [31:0]                  pout_q, pout_d;
	logic [fatcc_pkg::OFFS_W-1:0] offs_q, offs_d;

	// output register
	logic                 out_valid_q, out_valid_d;
	fatcc_pkg::out_item_t out_q, out_d;

	// table port
	fatcc_pkg::tab_wr_t tab_wr;
	logic [15:0]        rd_addr;
	logic [15:0]        tab_rdata;

	// seek setup
	logic [3:0]  bps_eff;
	logic [4:0]  shamt;
	logic [31:0] pos_shr;
	logic [31:0] offs_mask;
	logic [2:0]  rd_class;
	logic [31:0] sector;

	fatcc_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tab_wr),
		.rd_addr (rd_addr),
		.rd_data (tab_rdata)
	);

	assign in_ready = (state_q == fatcc_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= fatcc_pkg::CLUSTER_COUNT_RST;
			data_start_q <= 32'd0;
			spc_log2_q <= 3'd0;
			bps_log2_q <= fatcc_pkg::BPS_MIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				fatcc_pkg::CFG_CLUSTER_COUNT: cluster_count_q <= cfg_data[fatcc_pkg::CNT_W-1:0];
				fatcc_pkg::CFG_DATA_START:    data_start_q <= cfg_data;
				fatcc_pkg::CFG_SPC_LOG2:      spc_log2_q <= cfg_data[2:0];
				fatcc_pkg::CFG_BPS_LOG2:      bps_log2_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// cluster size: sector size clamped to 512..4096 bytes
	always_comb begin
		if (bps_log2_q < fatcc_pkg::BPS_MIN)
			bps_eff = fatcc_pkg::BPS_MIN;
		else if (bps_log2_q > fatcc_pkg::BPS_MAX)
			bps_eff = fatcc_pkg::BPS_MAX;
		else
			bps_eff = bps_log2_q;
		shamt = 5'(bps_eff) + 5'(spc_log2_q);
		pos_shr = pos_q >> shamt;
		offs_mask = (32'd1 << shamt) - 32'd1;
	end

	assign rd_class = fatcc_pkg::link_class(tab_rdata);
	assign sector = (cout_q >= fatcc_pkg::CL_FIRST)
		? data_start_q + (32'(cout_q - fatcc_pkg::CL_FIRST) << spc_log2_q)
		: 32'd0;

	// sequencer: next state, table accesses and datapath updates
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		cl_d = cl_q;
		edata_d = edata_q;
		pos_d = pos_q;
		cur_d = cur_q;
		skip_d = skip_q;
		scan_d = scan_q;
		lim_d = lim_q;
		rd_pend_d = 1'b0;
		rd_idx_d = rd_idx_s1;
		status_d = status_q;
		cout_d = cout_q;
		link_d = link_q;
		freed_d = freed_q;
		pout_d = pout_q;
		offs_d = offs_q;
		out_valid_d = out_valid_q && !out_ready;
		out_d = out_q;
		tab_wr = '0;
		rd_addr = cur_q;

		case (state_q)
			fatcc_pkg::S_IDLE: begin
				if (in_valid) begin
					op_d = in_item.opcode;
					cl_d = in_item.cluster;
					edata_d = in_item.entry_data;
					pos_d = (in_item.byte_position > in_item.file_length)
						? in_item.file_length : in_item.byte_position;
					state_d = fatcc_pkg::S_DISPATCH;
				end
			end

			fatcc_pkg::S_DISPATCH: begin
				status_d = fatcc_pkg::ST_LINK;
				cout_d = 16'd0;
				link_d = 16'd0;
				freed_d = '0;
				pout_d = 32'd0;
				offs_d = '0;
				cur_d = cl_q;
				state_d = fatcc_pkg::S_DONE;
				case (op_q)
					fatcc_pkg::OP_LOAD: begin
						tab_wr = '{en: 1'b1, addr: cl_q, data: edata_q};
					end
					fatcc_pkg::OP_READ: begin
						rd_addr = cl_q;
						state_d = fatcc_pkg::S_READ;
					end
					fatcc_pkg::OP_ALLOC: begin
						scan_d = fatcc_pkg::CNT_W'(fatcc_pkg::CL_FIRST);
						lim_d = (32'(cluster_count_q) > fatcc_pkg::TABLE_ENTRIES)
							? fatcc_pkg::CNT_W'(fatcc_pkg::TABLE_ENTRIES) : cluster_count_q;
						state_d = fatcc_pkg::S_ALLOC_SCAN;
					end
					fatcc_pkg::OP_FREE: begin
						if (cl_q >= fatcc_pkg::CL_FIRST && cl_q < fatcc_pkg::LINK_EOC_MIN
							&& 32'(cl_q) < fatcc_pkg::TABLE_ENTRIES) begin
							rd_addr = cl_q;
							state_d = fatcc_pkg::S_FREE;
						end
					end
					fatcc_pkg::OP_SEEK: begin
						pout_d = pos_q;
						offs_d = pos_q[fatcc_pkg::OFFS_W-1:0] & offs_mask[fatcc_pkg::OFFS_W-1:0];
						skip_d = pos_shr[fatcc_pkg::SKIP_W-1:0];
						cout_d = cl_q;
						if (pos_shr != 32'd0) begin
							rd_addr = cl_q;
							state_d = fatcc_pkg::S_WALK;
						end
					end
					default: ;
				endcase
			end

			fatcc_pkg::S_READ: begin
				link_d = tab_rdata;
				status_d = rd_class;
				cout_d = (rd_class == fatcc_pkg::ST_LINK) ? tab_rdata : 16'd0;
				state_d = fatcc_pkg::S_DONE;
			end

			// reads issue one per cycle; data for rd_idx_s1 is checked in the next cycle
			fatcc_pkg::S_ALLOC_SCAN: begin
				if (rd_pend_s1 && tab_rdata == fatcc_pkg::LINK_FREE) begin
					tab_wr = '{en: 1'b1, addr: rd_idx_s1, data: fatcc_pkg::LINK_EOC};
					cout_d = rd_idx_s1;
					if (cl_q != 16'd0 && cl_q != rd_idx_s1)
						state_d = fatcc_pkg::S_ALLOC_LINK;
					else
						state_d = fatcc_pkg::S_DONE;
				end else if (!rd_pend_s1 && scan_q >= lim_q) begin
					status_d = fatcc_pkg::ST_FULL;
					state_d = fatcc_pkg::S_DONE;
				end else if (scan_q < lim_q) begin
					rd_addr = 16'(scan_q);
					rd_idx_d = 16'(scan_q);
					rd_pend_d = 1'b1;
					scan_d = scan_q + 1'b1;
				end
			end

			fatcc_pkg::S_ALLOC_LINK: begin
				tab_wr = '{en: 1'b1, addr: cl_q, data: cout_q};
				state_d = fatcc_pkg::S_DONE;
			end

			// clear cur, fetch its successor in the same cycle (table forwards the clear)
			fatcc_pkg::S_FREE: begin
				tab_wr = '{en: 1'b1, addr: cur_q, data: fatcc_pkg::LINK_FREE};
				if (freed_q != fatcc_pkg::FREED_MAX)
					freed_d = freed_q + 1'b1;
				if (tab_rdata < fatcc_pkg::CL_FIRST || tab_rdata == fatcc_pkg::LINK_BAD) begin
					state_d = fatcc_pkg::S_DONE;
				end else begin
					cur_d = tab_rdata;
					if (tab_rdata < fatcc_pkg::LINK_EOC_MIN
						&& 32'(tab_rdata) < fatcc_pkg::TABLE_ENTRIES)
						rd_addr = tab_rdata;
					else
						state_d = fatcc_pkg::S_DONE;
				end
			end

			fatcc_pkg::S_WALK: begin
				if (rd_class != fatcc_pkg::ST_LINK) begin
					status_d = rd_class;
					state_d = fatcc_pkg::S_DONE;
				end else begin
					cur_d = tab_rdata;
					cout_d = tab_rdata;
					skip_d = skip_q - 1'b1;
					if (skip_q == fatcc_pkg::SKIP_W'(1))
						state_d = fatcc_pkg::S_DONE;
					else
						rd_addr = tab_rdata;
				end
			end

			fatcc_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_d = '{
						status: status_q,
						cluster_out: cout_q,
						link_value: link_q,
						sector_address: sector,
						freed_count: freed_q,
						position_out: pout_q,
						offset_in_cluster: offs_q
					};
					out_valid_d = 1'b1;
					state_d = fatcc_pkg::S_IDLE;
				end
			end

			default: state_d = fatcc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fatcc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
			rd_pend_s1 <= rd_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		cl_q <= cl_d;
		edata_q <= edata_d;
		pos_q <= pos_d;
		cur_q <= cur_d;
		skip_q <= skip_d;
		scan_q <= scan_d;
		lim_q <= lim_d;
		rd_idx_s1 <= rd_idx_d;
		status_q <= status_d;
		cout_q <= cout_d;
		link_q <= link_d;
		freed_q <= freed_d;
		pout_q <= pout_d;
		offs_q <= offs_d;
		out_q <= out_d;
	end

endmodule

// ===== rtl/core/fatcc_table.sv =====
// Cluster table RAM: one write and one registered read port, same-cycle write forwarding.
module fatcc_table (
	input  logic                clk,
	input  logic                arst_n,
	input  fatcc_pkg::tab_wr_t  wr,
	input  logic [15:0]         rd_addr,
	output logic [15:0]         rd_data
);

	logic [15:0] mem [fatcc_pkg::TABLE_ENTRIES];
	logic [15:0] mem_q;
	logic [15:0] fwd_data_q;
	logic        fwd_hit_q;
	logic        rd_oob_q;
	logic        wr_in_range;
	logic        rd_in_range;

	assign wr_in_range = 32'(wr.addr) < fatcc_pkg::TABLE_ENTRIES;
	assign rd_in_range = 32'(rd_addr) < fatcc_pkg::TABLE_ENTRIES;

	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			mem[wr.addr[fatcc_pkg::IDX_W-1:0]] <= wr.data;
		end
		mem_q <= mem[rd_addr[fatcc_pkg::IDX_W-1:0]];
		fwd_data_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
			rd_oob_q <= 1'b0;
		end else begin
			fwd_hit_q <= wr.en && (wr.addr == rd_addr);
			rd_oob_q <= !rd_in_range;
		end
	end

	// entries beyond the table read as zero
	assign rd_data = rd_oob_q ? 16'h0000 : (fwd_hit_q ? fwd_data_q : mem_q);

endmodule

// ===== rtl/core/fatcc_checker.sv =====
// Port-level checks for the FAT16 cluster chain engine, bound to the top level.
module fatcc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input fatcc_pkg::out_item_t out_item
);

	// held result must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == fatcc_pkg::ST_FULL
		|-> out_item.cluster_out == 16'd0 && out_item.sector_address == 32'd0)
		else $error("failed allocation reports a cluster");

	a_sector_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.cluster_out < fatcc_pkg::CL_FIRST
		|-> out_item.sector_address == 32'd0)
		else $error("sector for cluster below 2");

	a_freed_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.freed_count != '0
		|-> out_item.cluster_out == 16'd0 && out_item.status == fatcc_pkg::ST_LINK)
		else $error("free chain result carries other fields");

endmodule

bind fat16_cluster_chain_engine fatcc_checker u_fatcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
